### rtl/core/dcr_pkg.sv
// ----------------------------------------------------------------------------
// dcr_pkg
// Shared types and constants of the DMA channel register block.
// ----------------------------------------------------------------------------
`default_nettype none

package dcr_pkg;

    localparam int NUM_CHANNELS = 7;
    localparam int RAM_BYTES    = 2097152;
    localparam int RAM_AW       = $clog2(RAM_BYTES);
    localparam int CH_W         = $clog2(NUM_CHANNELS);
    localparam int MEM_AW       = 21;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [7:0] OFF_CONTROL = 8'hF0;
    localparam logic [3:0] SUB_BASE    = 4'h0;
    localparam logic [3:0] SUB_BLOCK   = 4'h4;
    localparam logic [3:0] SUB_CTRL    = 4'h8;

    localparam logic [CH_W-1:0] CH_GPU   = CH_W'(2);
    localparam logic [CH_W-1:0] CH_CDROM = CH_W'(3);
    localparam logic [CH_W-1:0] CH_OTC   = CH_W'(6);
    localparam logic [CH_W-1:0] CH_NONE  = CH_W'(7);

    localparam logic [1:0] MODE_WORDS  = 2'd0;
    localparam logic [1:0] MODE_BLOCKS = 2'd1;

    localparam logic [23:0] TERMINATOR = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  reg_offset;
        logic [31:0] write_data;
    } dcr_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        mem_write_valid;
        logic [20:0] mem_address;
        logic [23:0] mem_data;
        logic        irq_pulse;
    } dcr_out_t;

    // ctrl: [5] trigger, [4] start, [3:2] mode, [1] step, [0] direction
    typedef struct packed {
        logic [23:0] base;
        logic [15:0] block_count;
        logic [15:0] block_size;
        logic [15:0] word_count;
        logic [5:0]  ctrl;
    } chan_rec_t;

    typedef struct packed {
        logic        load;
        logic        step;
        logic [23:0] base;
        logic [15:0] count;
    } otc_cmd_t;

    typedef struct packed {
        logic        mem_write_valid;
        logic [20:0] mem_address;
        logic [23:0] mem_data;
        logic        done;
    } otc_stat_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } dcr_state_t;

endpackage

`default_nettype wire

### rtl/core/dcr_chan_mem.sv
// ----------------------------------------------------------------------------
// dcr_chan_mem
// Per-channel register store: one entry per channel, registered read,
// per-entry valid bits so unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dcr_chan_mem
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     rd_en,
    input  wire logic [dcr_pkg::CH_W-1:0] rd_idx,
    output dcr_pkg::chan_rec_t            rd_data,
    input  wire logic                     wr_en,
    input  wire logic [dcr_pkg::CH_W-1:0] wr_idx,
    input  wire dcr_pkg::chan_rec_t       wr_data
);
    import dcr_pkg::*;

    chan_rec_t               mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] vld_reg;
    chan_rec_t               rdata_reg;
    logic                    rvld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld_reg <= vld_reg[rd_idx];
            end
        end
    end

    assign rd_data = rvld_reg ? rdata_reg : '0;

    a_rd_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> rd_idx != CH_NONE)
        else $error("channel store read beyond last channel");
    a_wr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> wr_idx != CH_NONE)
        else $error("channel store write beyond last channel");
    a_wr_sets_vld: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> vld_reg[$past(wr_idx)])
        else $error("written entry not marked valid");

endmodule

`default_nettype wire

### rtl/core/dcr_otc.sv
// ----------------------------------------------------------------------------
// dcr_otc
// Table-clear engine: walks a descending chain of link words, one per step.
// ----------------------------------------------------------------------------
`default_nettype none

module dcr_otc
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dcr_pkg::otc_cmd_t cmd,
    output dcr_pkg::otc_stat_t stat
);
    import dcr_pkg::*;

    logic              active_reg, active_next;
    logic [RAM_AW-1:0] addr_reg, addr_next;
    logic [15:0]       remaining_reg, remaining_next;
    logic [RAM_AW-1:0] step_addr;
    logic [23:0]       addr_wide;
    logic              last;

    assign step_addr = {addr_reg[RAM_AW-1:2] - (RAM_AW-2)'(1), 2'b00};
    assign addr_wide = 24'(addr_reg);
    assign last      = (remaining_reg <= 16'd1);

    always_comb
    begin
        stat.mem_write_valid = active_reg;
        stat.mem_address     = active_reg ? addr_wide[MEM_AW-1:0] : '0;
        stat.mem_data        = !active_reg ? '0 : (last ? TERMINATOR : 24'(step_addr));
        stat.done            = active_reg && last;

        active_next    = active_reg;
        addr_next      = addr_reg;
        remaining_next = remaining_reg;
        if (cmd.load)
        begin
            active_next    = (cmd.count != 16'd0);
            addr_next      = {cmd.base[RAM_AW-1:2], 2'b00};
            remaining_next = cmd.count;
        end
        else if (cmd.step && active_reg)
        begin
            if (last)
            begin
                active_next    = 1'b0;
                remaining_next = '0;
            end
            else
            begin
                addr_next      = step_addr;
                remaining_next = remaining_reg - 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            addr_reg      <= '0;
            remaining_reg <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            addr_reg      <= addr_next;
            remaining_reg <= remaining_next;
        end
    end

    a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> remaining_reg != 16'd0)
        else $error("engine running with zero count");
    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        addr_reg[1:0] == 2'b00)
        else $error("engine address not word aligned");
    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && !cmd.load && stat.done |=> !active_reg)
        else $error("engine still running after last word");

endmodule

`default_nettype wire

### rtl/core/dma_channel_registers_with_otc_engine_unit.sv
// ----------------------------------------------------------------------------
// dma_channel_registers_with_otc_engine_unit
// Seven-channel DMA register block with a table-clear engine on channel 6.
//
// Input words carry a tick, a register read or a register write; each word
// yields exactly one output word (read data, table memory write, interrupt).
// Per-channel registers sit in a small synchronous store; each word reads its
// channel entry, then modifies and writes it back in the execute state.
// The accepted word is held in the execute state; its result is then
// registered in the output register. Owing to the store's read-then-write
// turn, a new word is taken only once the previous one has left the execute state, while its result may still wait.
// A stalled receiver holds the result; the next word then waits in the
// execute state until the output register frees up.
// Reset clears all channel registers, enables, control value and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dma_channel_registers_with_otc_engine_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire dcr_pkg::dcr_in_t in_data,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output dcr_pkg::dcr_out_t out_data
);
    import dcr_pkg::*;

    dcr_state_t              state_reg, state_next;
    dcr_in_t                 item_reg;
    dcr_out_t                out_reg, out_next;
    logic                    out_valid_reg;
    logic [31:0]             control_reg, control_next;
    logic [NUM_CHANNELS-1:0] enable_reg, enable_next;

    logic                    accept;
    logic                    commit;
    logic [CH_W-1:0]         acc_ch;
    logic [CH_W-1:0]         ch;
    logic [3:0]              sub;
    logic                    chan_hit;
    chan_rec_t               entry;
    chan_rec_t               entry_new;
    logic                    wr_en;
    logic [5:0]              cb;
    otc_cmd_t                cmd;
    otc_stat_t               stat;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign commit    = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        if (in_data.opcode == OP_TICK || in_data.reg_offset[6:4] == CH_NONE)
        begin
            acc_ch = CH_OTC;
        end
        else
        begin
            acc_ch = in_data.reg_offset[6:4];
        end
    end

    dcr_chan_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_idx  (acc_ch),
        .rd_data (entry),
        .wr_en   (wr_en),
        .wr_idx  (ch),
        .wr_data (entry_new)
    );

    dcr_otc u_otc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign ch       = (item_reg.opcode == OP_TICK) ? CH_OTC : item_reg.reg_offset[6:4];
    assign sub      = item_reg.reg_offset[3:0];
    assign chan_hit = item_reg.reg_offset[7] && (item_reg.reg_offset[6:4] != CH_NONE);
    assign cb       = {item_reg.write_data[28], item_reg.write_data[24],
                       item_reg.write_data[10:9], item_reg.write_data[1:0]};

    always_comb
    begin
        state_next   = state_reg;
        out_next     = '0;
        control_next = control_reg;
        enable_next  = enable_reg;
        entry_new    = entry;
        wr_en        = 1'b0;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.base     = entry.base;
        cmd.count    = entry.word_count;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (item_reg.opcode == OP_READ)
                begin
                    if (item_reg.reg_offset == OFF_CONTROL)
                    begin
                        out_next.read_data = control_reg;
                    end
                    else if (chan_hit)
                    begin
                        case (sub)
                            SUB_BASE:
                            begin
                                out_next.read_data = 32'(entry.base);
                            end
                            SUB_BLOCK:
                            begin
                                if (entry.ctrl[3:2] == MODE_WORDS)
                                begin
                                    out_next.read_data = 32'(entry.word_count);
                                end
                                else if (entry.ctrl[3:2] == MODE_BLOCKS)
                                begin
                                    out_next.read_data = {entry.block_count, entry.block_size};
                                end
                            end
                            SUB_CTRL:
                            begin
                                out_next.read_data[1:0]  = entry.ctrl[1:0];
                                out_next.read_data[10:9] = entry.ctrl[3:2];
                                out_next.read_data[24]   = entry.ctrl[4];
                                out_next.read_data[28]   = entry.ctrl[5];
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                else if (item_reg.opcode == OP_WRITE)
                begin
                    if (item_reg.reg_offset == OFF_CONTROL)
                    begin
                        control_next = item_reg.write_data;
                        for (int c = 0; c < NUM_CHANNELS; c++)
                        begin
                            enable_next[c] = item_reg.write_data[4*c+3];
                        end
                    end
                    else if (chan_hit)
                    begin
                        case (sub)
                            SUB_BASE:
                            begin
                                entry_new.base = item_reg.write_data[23:0];
                                wr_en          = commit;
                            end
                            SUB_BLOCK:
                            begin
                                entry_new.block_count = item_reg.write_data[31:16];
                                entry_new.block_size  = item_reg.write_data[15:0];
                                entry_new.word_count  = item_reg.write_data[15:0];
                                wr_en                 = commit;
                            end
                            SUB_CTRL:
                            begin
                                entry_new.ctrl = cb;
                                wr_en          = commit;
                                if (enable_reg[ch] && cb[4])
                                begin
                                    if (ch == CH_GPU || ch == CH_CDROM)
                                    begin
                                        entry_new.ctrl[5:4] = 2'b00;
                                        out_next.irq_pulse  = 1'b1;
                                    end
                                    else if (ch == CH_OTC)
                                    begin
                                        cmd.load = commit;
                                        if (entry.word_count == 16'd0)
                                        begin
                                            entry_new.ctrl[5:4] = 2'b00;
                                            out_next.irq_pulse  = 1'b1;
                                        end
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                else if (item_reg.opcode == OP_TICK)
                begin
                    cmd.step                 = commit;
                    out_next.mem_write_valid = stat.mem_write_valid;
                    out_next.mem_address     = stat.mem_address;
                    out_next.mem_data        = stat.mem_data;
                    if (stat.done)
                    begin
                        out_next.irq_pulse   = 1'b1;
                        entry_new.ctrl[5:4]  = 2'b00;
                        entry_new.word_count = '0;
                        wr_en                = commit;
                    end
                end

                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            control_reg   <= '0;
            enable_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                control_reg   <= control_next;
                enable_reg    <= enable_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (commit)
        begin
            out_reg <= out_next;
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted word did not enter execute");
    a_memwr_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.mem_write_valid |-> out_reg.read_data == 32'd0)
        else $error("table write carries read data");
    a_irq_terminator: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.irq_pulse && out_reg.mem_write_valid
            |-> out_reg.mem_data == TERMINATOR)
        else $error("completing table write is not the terminator");

endmodule

`default_nettype wire

### dv/dma_channel_registers_with_otc_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// dma_channel_registers_with_otc_engine_unit_tb
// Self-checking bench for the DMA channel register block. A tracker class
// mirrors the channel registers, enables and table-clear engine, predicts one
// result per accepted word and checks every returned word field by field.
// Directed register and table-clear cases are followed by random traffic under
// several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module dma_channel_registers_with_otc_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dcr_pkg::*;

    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam int          CB_START       = 4;
    localparam logic [5:0]  RUN_BITS       = 6'b110000;
    localparam int          WD_START       = 24;
    localparam int          WD_TRIG        = 28;
    localparam int          OTC_ENABLE_BIT = 4 * int'(CH_OTC) + 3;
    localparam logic [20:0] RAM_WORD_MASK  = 21'(RAM_BYTES - 4);
    localparam logic [7:0]  OTC_BASE_OFF   = {4'(int'(CH_OTC) + 8), SUB_BASE};
    localparam logic [7:0]  OTC_BLOCK_OFF  = {4'(int'(CH_OTC) + 8), SUB_BLOCK};
    localparam logic [7:0]  OTC_CTRL_OFF   = {4'(int'(CH_OTC) + 8), SUB_CTRL};

    class chan_reg_tracker;
        logic [23:0] base       [NUM_CHANNELS];
        logic [15:0] blk_count  [NUM_CHANNELS];
        logic [15:0] blk_size   [NUM_CHANNELS];
        logic [15:0] word_count [NUM_CHANNELS];
        logic [5:0]  ctrl       [NUM_CHANNELS];
        logic [6:0]  enable;
        logic [31:0] control_value;
        bit          otc_busy;
        logic [20:0] otc_addr;
        logic [15:0] otc_left;
        dcr_out_t    expected_results[$];
        int          n_in;
        int          n_out;
        int          n_fail;
        int          n_mem;
        int          n_irq;

        function new();
            foreach (base[c])
            begin
                base[c]       = '0;
                blk_count[c]  = '0;
                blk_size[c]   = '0;
                word_count[c] = '0;
                ctrl[c]       = '0;
            end
            enable        = '0;
            control_value = '0;
            otc_busy      = 0;
            otc_addr      = '0;
            otc_left      = '0;
        endfunction

        function logic [31:0] read_reg(logic [7:0] off);
            int          ch;
            logic [5:0]  cb;
            if (off == OFF_CONTROL)
                return control_value;
            if (off < 8'h80 || off > OFF_CONTROL)
                return '0;
            ch = off[7:4] - 8;
            cb = ctrl[ch];
            case (off[3:0])
                SUB_BASE:
                    return {8'h00, base[ch]};
                SUB_BLOCK:
                begin
                    if (cb[3:2] == MODE_WORDS)
                        return {16'h0000, word_count[ch]};
                    if (cb[3:2] == MODE_BLOCKS)
                        return {blk_count[ch], blk_size[ch]};
                    return '0;
                end
                SUB_CTRL:
                    return {3'b000, cb[5], 3'b000, cb[4], 13'h0000, cb[3:2], 7'h00,
                            cb[1], cb[0]};
                default:
                    return '0;
            endcase
        endfunction

        // returns the interrupt pulse of an immediate completion
        function bit write_reg(logic [7:0] off, logic [31:0] d);
            int          ch;
            logic [5:0]  cb;
            if (off == OFF_CONTROL)
            begin
                control_value = d;
                for (int c = 0; c < NUM_CHANNELS; c++)
                    enable[c] = d[4*c+3];
                return 0;
            end
            if (off < 8'h80 || off > OFF_CONTROL)
                return 0;
            ch = off[7:4] - 8;
            case (off[3:0])
                SUB_BASE:
                    base[ch] = d[23:0];
                SUB_BLOCK:
                begin
                    blk_count[ch]  = d[31:16];
                    blk_size[ch]   = d[15:0];
                    word_count[ch] = d[15:0];
                end
                SUB_CTRL:
                begin
                    cb = {d[WD_TRIG], d[WD_START], d[10:9], d[1], d[0]};
                    ctrl[ch] = cb;
                    if (!enable[ch] || !cb[CB_START])
                        return 0;
                    if (ch == CH_GPU || ch == CH_CDROM)
                    begin
                        ctrl[ch] = cb & ~RUN_BITS;
                        return 1;
                    end
                    if (ch == CH_OTC)
                    begin
                        if (word_count[CH_OTC] == 0)
                        begin
                            otc_busy     = 0;
                            otc_left     = '0;
                            ctrl[CH_OTC] = cb & ~RUN_BITS;
                            return 1;
                        end
                        otc_busy = 1;
                        otc_addr = base[CH_OTC][20:0] & RAM_WORD_MASK;
                        otc_left = word_count[CH_OTC];
                    end
                end
                default: ;
            endcase
            return 0;
        endfunction

        function dcr_out_t predict_result(dcr_in_t w);
            dcr_out_t r;
            r = '0;
            case (w.opcode)
                OP_READ:
                    r.read_data = read_reg(w.reg_offset);
                OP_WRITE:
                    r.irq_pulse = write_reg(w.reg_offset, w.write_data);
                OP_TICK:
                begin
                    if (otc_busy)
                    begin
                        r.mem_write_valid = 1'b1;
                        r.mem_address     = otc_addr;
                        if (otc_left <= 1)
                        begin
                            r.mem_data             = TERMINATOR;
                            r.irq_pulse            = 1'b1;
                            otc_busy               = 0;
                            otc_left               = '0;
                            ctrl[CH_OTC]           = ctrl[CH_OTC] & ~RUN_BITS;
                            word_count[CH_OTC]     = '0;
                        end
                        else
                        begin
                            otc_addr   = (otc_addr - 21'd4) & RAM_WORD_MASK;
                            r.mem_data = {3'b000, otc_addr};
                            otc_left   = otc_left - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_word(dcr_in_t w);
            n_in++;
            expected_results.push_back(predict_result(w));
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
            if (act !== exp)
            begin
                n_fail++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp, act);
            end
        endfunction

        function void check_result(dcr_out_t got);
            dcr_out_t e;
            n_out++;
            if (got.mem_write_valid === 1'b1)
                n_mem++;
            if (got.irq_pulse === 1'b1)
                n_irq++;
            if (expected_results.size() == 0)
            begin
                n_fail++;
                $display("%0t: result with nothing expected: expected none, actual %h",
                         $time, got);
                return;
            end
            e = expected_results.pop_front();
            compare_field("read_data", e.read_data, got.read_data);
            compare_field("mem_write_valid", 32'(e.mem_write_valid),
                          32'(got.mem_write_valid));
            compare_field("mem_address", 32'(e.mem_address), 32'(got.mem_address));
            compare_field("mem_data", 32'(e.mem_data), 32'(got.mem_data));
            compare_field("irq_pulse", 32'(e.irq_pulse), 32'(got.irq_pulse));
        endfunction
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    dcr_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    dcr_out_t out_data;

    chan_reg_tracker chan_regs = new();

    int idle_pct    = 0;
    int stall_pct   = 0;
    int words_sent  = 0;
    int hold_left   = 0;
    int holds_taken = 0;

    always #5 clk = ~clk;

    dma_channel_registers_with_otc_engine_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                chan_regs.note_word(in_data);
            if (out_valid && out_ready)
                chan_regs.check_result(out_data);
        end
    end

    // long output stalls while the sender keeps pushing
    always @(negedge clk)
    begin
        if (hold_left == 0 && holds_taken < 2 && chan_regs.n_in >= 100 + 200 * holds_taken)
        begin
            hold_left = 150;
            holds_taken++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #5_000_000;
        $display("[dma_channel_registers_with_otc_engine_unit] ERROR");
        $finish;
    end

    task automatic send_word(dcr_in_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic put(logic [1:0] op, logic [7:0] off, logic [31:0] d);
        dcr_in_t w;
        w.opcode     = op;
        w.reg_offset = off;
        w.write_data = d;
        send_word(w);
    endtask

    function automatic logic [7:0] chan_off(int ch, logic [3:0] sub);
        return {4'(ch + 8), sub};
    endfunction

    function automatic logic [7:0] random_reg_off();
        logic [3:0] sub;
        if ($urandom_range(9) == 0)
            return OFF_CONTROL;
        case ($urandom_range(2))
            0:       sub = SUB_BASE;
            1:       sub = SUB_BLOCK;
            default: sub = SUB_CTRL;
        endcase
        return chan_off($urandom_range(NUM_CHANNELS - 1), sub);
    endfunction

    task automatic random_word();
        int          r;
        logic [7:0]  off;
        logic [31:0] d;
        r   = $urandom_range(99);
        off = random_reg_off();
        d   = $urandom;
        if (r < 35)
            put(OP_TICK, 8'($urandom_range(255)), $urandom);
        else if (r < 60)
            put(OP_READ, off, d);
        else if (r < 85)
        begin
            if (off[3:0] == SUB_CTRL && $urandom_range(1))
                d[WD_START] = 1'b1;
            put(OP_WRITE, off, d);
        end
        else
            put(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom);
    endtask

    task automatic run_table_clear();
        int          n;
        logic [31:0] d;
        n = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(12);
        d = $urandom;
        if ($urandom_range(9) != 0)
            d[OTC_ENABLE_BIT] = 1'b1;
        put(OP_WRITE, OFF_CONTROL, d);
        put(OP_WRITE, OTC_BASE_OFF, $urandom);
        d = $urandom;
        d[15:0] = n[15:0];
        put(OP_WRITE, OTC_BLOCK_OFF, d);
        d = $urandom;
        d[WD_START] = 1'b1;
        put(OP_WRITE, OTC_CTRL_OFF, d);
        repeat (n + 1)
        begin
            if ($urandom_range(99) < 20)
                random_word();
            put(OP_TICK, 8'($urandom_range(255)), $urandom);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (chan_regs.expected_results.size() != 0);
    endtask

    task automatic run_phase(int send_idle, int recv_stall, int n_words);
        int target;
        target    = words_sent + n_words;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        while (words_sent < target)
        begin
            if ($urandom_range(99) < 15)
                run_table_clear();
            else
                random_word();
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        put(OP_READ, OFF_CONTROL, 32'h0);
        put(OP_WRITE, OFF_CONTROL, 32'hFFFF_FFFF);
        put(OP_READ, OFF_CONTROL, 32'h0);
        // table clear from the top of memory, three words
        put(OP_WRITE, OTC_BASE_OFF, 32'hFFFF_FFFF);
        put(OP_WRITE, OTC_BLOCK_OFF, 32'h0000_0003);
        put(OP_WRITE, OTC_CTRL_OFF, 32'h1100_0000);
        repeat (4) put(OP_TICK, 8'h00, 32'h0);
        put(OP_READ, OTC_BLOCK_OFF, 32'h0);
        put(OP_READ, OTC_CTRL_OFF, 32'h0);
        // zero count completes at once
        put(OP_WRITE, OTC_CTRL_OFF, 32'h0100_0000);
        // base zero wraps downward; restart mid-run
        put(OP_WRITE, OTC_BASE_OFF, 32'h0);
        put(OP_WRITE, OTC_BLOCK_OFF, 32'hFFFF_0002);
        put(OP_WRITE, OTC_CTRL_OFF, 32'h0100_0603);
        put(OP_TICK, 8'hFF, 32'hFFFF_FFFF);
        put(OP_WRITE, OTC_CTRL_OFF, 32'h0100_0000);
        repeat (2) put(OP_TICK, 8'h00, 32'h0);
        put(OP_WRITE, chan_off(int'(CH_GPU), SUB_CTRL), 32'h1100_0000);
        put(OP_WRITE, chan_off(int'(CH_CDROM), SUB_CTRL), 32'h0100_0000);
        put(OP_WRITE, chan_off(0, SUB_CTRL), 32'h1100_0000);
        put(OP_READ, chan_off(0, SUB_CTRL), 32'h0);
        put(OP_WRITE, chan_off(1, SUB_BLOCK), 32'hABCD_1234);
        put(OP_WRITE, chan_off(1, SUB_CTRL), 32'h0000_0200);
        put(OP_READ, chan_off(1, SUB_BLOCK), 32'h0);
        put(OP_WRITE, OFF_CONTROL, 32'h0);
        put(OP_WRITE, chan_off(int'(CH_GPU), SUB_CTRL), 32'h0100_0000);
        put(OP_READ, chan_off(2, 4'hC), 32'h0);
        put(OP_READ, 8'hFF, 32'h0);
        put(OP_WRITE, 8'h00, 32'hFFFF_FFFF);
        put(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        wait_drained();

        run_phase(0, 0, 420);
        run_phase(77, 0, 410);
        run_phase(0, 77, 410);
        run_phase(11, 11, 410);

        wait_drained();
        repeat (10) @(negedge clk);

        $display("run covered %0d words in, %0d results, %0d table words, %0d interrupts",
                 chan_regs.n_in, chan_regs.n_out, chan_regs.n_mem, chan_regs.n_irq);
        $display("traffic: no idling, idle sender, stalled receiver, both idle, long stalls");
        if (chan_regs.n_fail == 0 && chan_regs.expected_results.size() == 0)
            $display("[dma_channel_registers_with_otc_engine_unit] OK");
        else
            $display("[dma_channel_registers_with_otc_engine_unit] ERROR");
        $finish;
    end

endmodule

### dma_channel_registers_with_otc_engine_unit.f
rtl/core/dcr_pkg.sv
rtl/core/dcr_chan_mem.sv
rtl/core/dcr_otc.sv
rtl/core/dma_channel_registers_with_otc_engine_unit.sv
dv/dma_channel_registers_with_otc_engine_unit_tb.sv
